// ===== design/zdv_pkg.sv =====
// Shared types and constants for the zigzag delta varint decoder.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package zdv_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LOW_W     = 7;
   localparam int unsigned WORD_W    = LOW_W + BYTE_W;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned MARK_W    = 16;
   localparam int unsigned COMP_W    = 2;
   localparam int unsigned COMP_NUM  = 3;
   localparam int unsigned HOLD_BIT  = 7;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 2;

   localparam logic [COMP_W-1:0] COUNT_RESET = 2'd3;
   localparam logic [COMP_W-1:0] COMP_LAST   = 2'd2;

   typedef enum logic {
      MODE_COORD = 1'b0,
      MODE_INDEX = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECODE_MODE     = 1'b0,
      CSR_COMPONENT_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      mode_type          decode_mode;
      logic [COMP_W-1:0] component_count;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [VALUE_W-1:0]  value;
      logic [COMP_W-1:0]   component;
   } result_type;

endpackage

`default_nettype wire

// ===== design/zdv_core.sv =====
// Decode state and per-byte datapath: varint assembly, zigzag delta
// accumulation and high-watermark indices. Depends on zdv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zdv_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [zdv_pkg::BYTE_W-1:0]    code_byte,
   input  wire logic                          restart,
   input  wire zdv_pkg::cfg_type              cfg,
   output zdv_pkg::result_type                result
);

   logic                           pending_ff, pending_in;
   logic [zdv_pkg::LOW_W-1:0]      low_ff, low_in;
   logic [zdv_pkg::VALUE_W-1:0]    acc_ff [zdv_pkg::COMP_NUM];
   logic [zdv_pkg::VALUE_W-1:0]    acc_in [zdv_pkg::COMP_NUM];
   logic [zdv_pkg::COMP_W-1:0]     count_ff, count_in;
   logic [zdv_pkg::MARK_W-1:0]     mark_ff, mark_in;

   logic                           pend_eff;
   logic [zdv_pkg::COMP_W-1:0]     comp;
   logic [zdv_pkg::COMP_W:0]       comp_next;
   logic [zdv_pkg::MARK_W-1:0]     mark_eff;
   logic [zdv_pkg::VALUE_W-1:0]    acc_sel;
   logic [zdv_pkg::VALUE_W-1:0]    delta;
   logic [zdv_pkg::VALUE_W-1:0]    acc_sum;
   logic [zdv_pkg::WORD_W-1:0]     word;
   logic                           hold;

   // Apply restart ahead of this byte, then assemble and decode the word
   always_comb begin
      pend_eff = restart ? 1'b0 : pending_ff;
      mark_eff = restart ? '0 : mark_ff;
      comp     = (restart || count_ff > zdv_pkg::COMP_LAST) ? '0 : count_ff;
      acc_sel  = restart ? '0 : acc_ff[comp];
      hold     = !pend_eff && code_byte[zdv_pkg::HOLD_BIT];
      word     = pend_eff ? {code_byte, low_ff}
                          : {{zdv_pkg::LOW_W{1'b0}}, code_byte};
      delta    = {{(zdv_pkg::VALUE_W-zdv_pkg::WORD_W+1){1'b0}}, word[zdv_pkg::WORD_W-1:1]}
               ^ {zdv_pkg::VALUE_W{word[0]}};
      acc_sum  = acc_sel + delta;
      comp_next = {1'b0, comp} + 3'd1;

      result.valid     = !hold;
      result.value     = acc_sum;
      result.component = comp;
      if (cfg.decode_mode == zdv_pkg::MODE_INDEX) begin
         result.value = {{(zdv_pkg::VALUE_W-zdv_pkg::MARK_W){1'b0}}, mark_eff}
                      - {{(zdv_pkg::VALUE_W-zdv_pkg::WORD_W){1'b0}}, word};
         result.component = '0;
      end
   end

   // Next state for an accepted byte
   always_comb begin
      pending_in = pending_ff;
      low_in     = low_ff;
      count_in   = count_ff;
      mark_in    = mark_ff;
      for (int i = 0; i < zdv_pkg::COMP_NUM; i++) begin
         acc_in[i] = acc_ff[i];
      end
      if (go) begin
         if (restart) begin
            count_in = '0;
            mark_in  = '0;
            for (int i = 0; i < zdv_pkg::COMP_NUM; i++) begin
               acc_in[i] = '0;
            end
         end
         if (hold) begin
            pending_in = 1'b1;
            low_in     = code_byte[zdv_pkg::LOW_W-1:0];
         end else begin
            pending_in = 1'b0;
            if (cfg.decode_mode == zdv_pkg::MODE_COORD) begin
               acc_in[comp] = acc_sum;
               count_in = (comp_next >= {1'b0, cfg.component_count})
                        ? '0 : comp_next[zdv_pkg::COMP_W-1:0];
            end else if (word == '0) begin
               mark_in = mark_eff + 16'd1;
            end else begin
               mark_in = mark_eff;
            end
         end
      end
   end

   // Hold decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         low_ff     <= '0;
         count_ff   <= '0;
         mark_ff    <= '0;
         for (int i = 0; i < zdv_pkg::COMP_NUM; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         pending_ff <= pending_in;
         low_ff     <= low_in;
         count_ff   <= count_in;
         mark_ff    <= mark_in;
         for (int i = 0; i < zdv_pkg::COMP_NUM; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/zigzag_delta_varint_decoder.sv =====
// Top level of the zigzag delta varint decoder: input register, result
// register, configuration registers. Depends on zdv_pkg and zdv_core.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_code_byte, req_restart
//   rsp_      out        rsp_valid/rsp_stall   rsp_decoded_value, rsp_component
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One byte per cycle sustained while rsp_stall is low; a request that completes
// a value goes through the input register, then the result register.
// The state update and the result come from one add/subtract between the
// input register and the result register.
// Synchronous reset clears decode state, valid flags and configuration; the
// payload registers are not reset; no sweep. While a result waits under
// rsp_stall, at most one more request is taken into the input register, then req_stall rises until the result drains.
`timescale 1ns / 1ps
`default_nettype none

module zigzag_delta_varint_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [zdv_pkg::BYTE_W-1:0]        req_code_byte,
   input  wire logic                              req_restart,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic signed [zdv_pkg::VALUE_W-1:0] rsp_decoded_value,
   output      logic [zdv_pkg::COMP_W-1:0]        rsp_component,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [zdv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [zdv_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                         in_valid_ff, in_valid_in;
   logic [zdv_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                         in_restart_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [zdv_pkg::VALUE_W-1:0]  out_value_ff;
   logic [zdv_pkg::COMP_W-1:0]   out_comp_ff;
   zdv_pkg::cfg_type             cfg_ff, cfg_in;
   zdv_pkg::result_type          result;
   logic                         out_free;
   logic                         go;
   logic                         take;

   // Advance when the result register is empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   zdv_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .code_byte (in_byte_ff),
      .restart   (in_restart_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   // Next values of the handshake flags and configuration
   always_comb begin
      in_valid_in  = take || (in_valid_ff && !go);
      out_valid_in = go ? result.valid : (out_valid_ff && rsp_stall);
      cfg_in       = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (zdv_pkg::csr_index_type'(csr_index))
            zdv_pkg::CSR_DECODE_MODE:
               cfg_in.decode_mode = zdv_pkg::mode_type'(csr_wdata[0]);
            zdv_pkg::CSR_COMPONENT_COUNT:
               cfg_in.component_count = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold control flags and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.decode_mode     <= zdv_pkg::MODE_COORD;
         cfg_ff.component_count <= zdv_pkg::COUNT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Capture request and result payloads
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff    <= req_code_byte;
         in_restart_ff <= req_restart;
      end
      if (go && result.valid) begin
         out_value_ff <= result.value;
         out_comp_ff  <= result.component;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_decoded_value = out_value_ff;
   assign rsp_component     = out_comp_ff;

endmodule

`default_nettype wire

// ===== design/zdv_checker.sv =====
// Port-level checks for the zigzag delta varint decoder, bound to the top.
// Depends on zdv_pkg and zigzag_delta_varint_decoder.
`timescale 1ns / 1ps
`default_nettype none

module zdv_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [zdv_pkg::VALUE_W-1:0]       rsp_decoded_value,
   input wire logic [zdv_pkg::COMP_W-1:0]        rsp_component
);

   // A stalled result stays and holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_decoded_value)
                                 && $stable(rsp_component))
      else $error("stalled result changed");

   // Requests back up only behind a waiting, stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // Component names one of three accumulators
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_component != 2'd3)
      else $error("component out of range");

   // No result straight out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind zigzag_delta_varint_decoder zdv_checker u_zdv_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_decoded_value (rsp_decoded_value),
   .rsp_component     (rsp_component)
);

`default_nettype wire
